FILE: rtl/core/debug_frame_deframer_crc16_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef DEBUG_FRAME_DEFRAMER_CRC16_MACROS_SVH
`define DEBUG_FRAME_DEFRAMER_CRC16_MACROS_SVH

// Same-cycle implication, checked on clk with rst_n as disable.
`define DFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked on clk with rst_n as disable.
`define DFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

FILE: rtl/core/dfd_pkg.sv
// Package with constants and the CRC16 byte update for the deframer.
`timescale 1ns / 1ps

package dfd_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned CNT_W        = 17;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // header byte offsets
    localparam logic [CNT_W-1:0] OFS_START0 = 17'd0;
    localparam logic [CNT_W-1:0] OFS_START1 = 17'd1;
    localparam logic [CNT_W-1:0] OFS_VER    = 17'd2;
    localparam logic [CNT_W-1:0] OFS_CMD    = 17'd3;
    localparam logic [CNT_W-1:0] OFS_SEQ0   = 17'd4;
    localparam logic [CNT_W-1:0] OFS_SEQ1   = 17'd5;
    localparam logic [CNT_W-1:0] OFS_ADR0   = 17'd6;
    localparam logic [CNT_W-1:0] OFS_ADR1   = 17'd7;
    localparam logic [CNT_W-1:0] OFS_ADR2   = 17'd8;
    localparam logic [CNT_W-1:0] OFS_ADR3   = 17'd9;
    localparam logic [CNT_W-1:0] OFS_LEN0   = 17'd10;
    localparam logic [CNT_W-1:0] OFS_LEN1   = 17'd11;

    // verdict status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_CRC   = 2'd3;

    // item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // config register indexes
    localparam logic CFG_START_FIRST  = 1'b0;
    localparam logic CFG_START_SECOND = 1'b1;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/debug_frame_deframer_crc16.sv
// Byte-serial deframer for CRC16 Modbus protected debug-link frames.
//
// Input stream: one buffer byte per transfer on s_tdata, s_tlast on the
// buffer's final byte. Output stream: m_tuser = 0 carries a payload byte,
// m_tuser = 1 carries the frame verdict (status plus decoded header in an
// ok verdict). At most one output transfer per input transfer.
// A result is registered onto m_tvalid in the cycle after its input transfer.
// Throughput: one byte per cycle while not stalled; the byte-wide CRC
// update, header capture and length compares all settle between the
// state registers and the output register.
// When the receiver stalls, the output register holds and s_tready drops
// only while a result is waiting and m_tready is low.
// Bytes after a completed frame produce nothing, s_tlast byte included.
// Config: cfg_we writes start_byte_first (index 0) or start_byte_second
// (index 1), only while the block is idle: the user's duty, not enforced.
// Reset (rst_n low, asynchronous): config registers and header fields to 0,
// CRC to 0xFFFF, byte count and flags cleared, output empty.
`timescale 1ns / 1ps
`include "debug_frame_deframer_crc16_macros.svh"

module debug_frame_deframer_crc16
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [9:8] status, [17:10] version, [25:18] command,
    // [41:26] sequence_res, [73:42] target_address, [89:74] payload_length,
    // [95:90] zero
    output logic [95:0] m_tdata,
    output logic        m_tuser,   // item_kind
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int unsigned CW = dfd_pkg::CNT_W;

    logic [7:0]    start0_reg, start1_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   crc_reg, crc_next;
    logic          mismatch_reg, mismatch_next;
    logic          done_reg, done_next;
    logic [7:0]    version_reg, version_next;
    logic [7:0]    command_reg, command_next;
    logic [15:0]   sequence_reg, sequence_next;
    logic [31:0]   address_reg, address_next;
    logic [15:0]   length_reg, length_next;
    logic [7:0]    crc_low_reg, crc_low_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_hdr_reg, out_hdr_next;

    logic          accept;
    logic [CW-1:0] body;
    logic          in_header, is_payload, is_crc_lo, is_complete;
    logic          res_valid;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // length is final once the header is in, which is all the compares need
    assign body        = CW'(dfd_pkg::HEADER_BYTES) + {1'b0, length_reg};
    assign in_header   = count_reg < CW'(dfd_pkg::HEADER_BYTES);
    assign is_payload  = !in_header && (count_reg < body);
    assign is_crc_lo   = !in_header && (count_reg == body);
    assign is_complete = !in_header && (count_reg == body + CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start0_reg <= 8'h00;
            start1_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dfd_pkg::CFG_START_FIRST:  start0_reg <= cfg_data;
                dfd_pkg::CFG_START_SECOND: start1_reg <= cfg_data;
                default:                   start0_reg <= start0_reg;
            endcase
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        crc_next        = crc_reg;
        mismatch_next   = mismatch_reg;
        done_next       = done_reg;
        version_next    = version_reg;
        command_next    = command_reg;
        sequence_next   = sequence_reg;
        address_next    = address_reg;
        length_next     = length_reg;
        crc_low_next    = crc_low_reg;
        res_valid       = 1'b0;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_hdr_next    = out_hdr_reg;

        if (accept)
        begin
            if (!done_reg)
            begin
                unique case (count_reg)
                    dfd_pkg::OFS_START0: if (s_tdata != start0_reg) mismatch_next = 1'b1;
                    dfd_pkg::OFS_START1: if (s_tdata != start1_reg) mismatch_next = 1'b1;
                    dfd_pkg::OFS_VER:    version_next          = s_tdata;
                    dfd_pkg::OFS_CMD:    command_next          = s_tdata;
                    dfd_pkg::OFS_SEQ0:   sequence_next[7:0]    = s_tdata;
                    dfd_pkg::OFS_SEQ1:   sequence_next[15:8]   = s_tdata;
                    dfd_pkg::OFS_ADR0:   address_next[7:0]     = s_tdata;
                    dfd_pkg::OFS_ADR1:   address_next[15:8]    = s_tdata;
                    dfd_pkg::OFS_ADR2:   address_next[23:16]   = s_tdata;
                    dfd_pkg::OFS_ADR3:   address_next[31:24]   = s_tdata;
                    dfd_pkg::OFS_LEN0:   length_next[7:0]      = s_tdata;
                    dfd_pkg::OFS_LEN1:   length_next[15:8]     = s_tdata;
                    default:             length_next           = length_reg;
                endcase

                if (in_header || is_payload)
                    crc_next = dfd_pkg::crc_feed(crc_reg, s_tdata);
                if (is_crc_lo)
                    crc_low_next = s_tdata;
                count_next = count_reg + CW'(1);

                priority if (is_complete)
                begin
                    res_valid     = 1'b1;
                    out_kind_next = dfd_pkg::KIND_VERDICT;
                    out_byte_next = 8'h00;
                    if (mismatch_reg)
                        out_status_next = dfd_pkg::ST_START;
                    else if ({s_tdata, crc_low_reg} != crc_reg)
                        out_status_next = dfd_pkg::ST_CRC;
                    else
                        out_status_next = dfd_pkg::ST_OK;
                    out_hdr_next = !mismatch_reg && ({s_tdata, crc_low_reg} == crc_reg);
                    done_next    = 1'b1;
                end
                else if (s_tlast)
                begin
                    res_valid     = 1'b1;
                    out_kind_next = dfd_pkg::KIND_VERDICT;
                    out_byte_next = 8'h00;
                    out_hdr_next  = 1'b0;
                    // too short for header plus CRC wins over a start error
                    if (count_reg >= CW'(dfd_pkg::HEADER_BYTES + 1) && mismatch_reg)
                        out_status_next = dfd_pkg::ST_START;
                    else
                        out_status_next = dfd_pkg::ST_LEN;
                end
                else if (is_payload)
                begin
                    res_valid       = 1'b1;
                    out_kind_next   = dfd_pkg::KIND_PAYLOAD;
                    out_byte_next   = s_tdata;
                    out_status_next = dfd_pkg::ST_OK;
                    out_hdr_next    = 1'b0;
                end
                else
                begin
                    res_valid = 1'b0;
                end
            end

            if (s_tlast)
            begin
                count_next    = '0;
                crc_next      = dfd_pkg::CRC_INIT;
                mismatch_next = 1'b0;
                done_next     = 1'b0;
            end
        end

        out_valid_next = res_valid || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_reg       <= dfd_pkg::CRC_INIT;
            mismatch_reg  <= 1'b0;
            done_reg      <= 1'b0;
            version_reg   <= 8'h00;
            command_reg   <= 8'h00;
            sequence_reg  <= 16'h0000;
            address_reg   <= 32'h0000_0000;
            length_reg    <= 16'h0000;
            crc_low_reg   <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            mismatch_reg  <= mismatch_next;
            done_reg      <= done_next;
            version_reg   <= version_next;
            command_reg   <= command_next;
            sequence_reg  <= sequence_next;
            address_reg   <= address_next;
            length_reg    <= length_next;
            crc_low_reg   <= crc_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a result is produced
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_hdr_reg    <= out_hdr_next;
        end
    end

    // header fields are stable while a verdict waits: a new frame cannot
    // be accepted past the stalled result
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'b000000,
                       out_hdr_reg ? length_reg   : 16'h0000,
                       out_hdr_reg ? address_reg  : 32'h0000_0000,
                       out_hdr_reg ? sequence_reg : 16'h0000,
                       out_hdr_reg ? command_reg  : 8'h00,
                       out_hdr_reg ? version_reg  : 8'h00,
                       out_status_reg,
                       out_byte_reg};

    `DFD_ASSERT_NEXT(a_last_restarts, accept && s_tlast, count_reg == '0 && !done_reg && !mismatch_reg)
    `DFD_ASSERT_NOW(a_done_at_total, done_reg, count_reg == body + CW'(2))
    `DFD_ASSERT_NOW(a_count_bound, count_reg > CW'(dfd_pkg::HEADER_BYTES), count_reg <= body + CW'(2))
    `DFD_ASSERT_NOW(a_payload_clean, m_tvalid && m_tuser == dfd_pkg::KIND_PAYLOAD, m_tdata[95:8] == '0)

endmodule

FILE: tb/debug_frame_deframer_crc16_test.sv
// Self-checking stream testbench for the CRC16 Modbus debug-link frame deframer.
`timescale 1ns / 1ps

module debug_frame_deframer_crc16_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned BYTES_PER_SEGMENT = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    // same layout as m_tdata, payload_byte in the low bits
    typedef struct packed {
        logic [5:0]  spare;
        logic [15:0] payload_length;
        logic [31:0] target_address;
        logic [15:0] sequence_res;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [1:0]  status;
        logic [7:0]  payload_byte;
    } deframe_word_t;

    typedef struct {
        logic          kind;
        deframe_word_t word;
    } deframe_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] data_byte
    logic        s_tlast = 1'b0;     // end_of_buffer
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;            // [7:0] payload_byte, [9:8] status, [17:10] version,
                                     // [25:18] command, [41:26] sequence_res,
                                     // [73:42] target_address, [89:74] payload_length
    logic        m_tuser;            // item_kind
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'h00;

    debug_frame_deframer_crc16 u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [7:0]  sof_first;
    logic [7:0]  sof_second;
    logic [16:0] rx_count;
    logic [15:0] crc_acc;
    logic        start_bad;
    logic        frame_complete;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_command;
    logic [15:0] hdr_sequence;
    logic [31:0] hdr_address;
    logic [15:0] hdr_length;
    logic [7:0]  crc_lo;

    stream_byte_t  pending_bytes[$];
    deframe_item_t expected_results[$];
    stream_byte_t  next_byte;
    deframe_item_t oldest_expected;
    deframe_word_t observed_word;
    logic [7:0]    frame_bytes[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8)
            acc = acc[0] ? ((acc >> 1) ^ dfd_pkg::CRC_POLY) : (acc >> 1);
        return acc;
    endfunction

    task automatic restart_buffer();
        rx_count = '0;
        crc_acc = dfd_pkg::CRC_INIT;
        start_bad = 1'b0;
        frame_complete = 1'b0;
    endtask

    task automatic clear_deframer_model();
        sof_first = 8'h00;
        sof_second = 8'h00;
        hdr_version = 8'h00;
        hdr_command = 8'h00;
        hdr_sequence = 16'h0000;
        hdr_address = 32'h0000_0000;
        hdr_length = 16'h0000;
        crc_lo = 8'h00;
        restart_buffer();
    endtask

    // Advances the model by one accepted byte and queues the result it causes.
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        int unsigned idx;
        int unsigned body;
        int unsigned total;
        int unsigned seen;
        logic        is_payload;
        deframe_item_t r;
        idx = 32'(rx_count);
        is_payload = 1'b0;
        r.kind = dfd_pkg::KIND_PAYLOAD;
        r.word = '0;
        if (frame_complete)
        begin
            if (last)
                restart_buffer();
            return;
        end
        case (rx_count)
            dfd_pkg::OFS_START0: if (b != sof_first) start_bad = 1'b1;
            dfd_pkg::OFS_START1: if (b != sof_second) start_bad = 1'b1;
            dfd_pkg::OFS_VER:    hdr_version = b;
            dfd_pkg::OFS_CMD:    hdr_command = b;
            dfd_pkg::OFS_SEQ0:   hdr_sequence[7:0] = b;
            dfd_pkg::OFS_SEQ1:   hdr_sequence[15:8] = b;
            dfd_pkg::OFS_ADR0:   hdr_address[7:0] = b;
            dfd_pkg::OFS_ADR1:   hdr_address[15:8] = b;
            dfd_pkg::OFS_ADR2:   hdr_address[23:16] = b;
            dfd_pkg::OFS_ADR3:   hdr_address[31:24] = b;
            dfd_pkg::OFS_LEN0:   hdr_length[7:0] = b;
            dfd_pkg::OFS_LEN1:   hdr_length[15:8] = b;
            default:    ;
        endcase
        body = dfd_pkg::HEADER_BYTES + 32'(hdr_length);
        total = body + 2;
        if (idx < dfd_pkg::HEADER_BYTES || idx < body)
            crc_acc = modbus_crc_step(crc_acc, b);
        if (idx >= dfd_pkg::HEADER_BYTES && idx < body)
            is_payload = 1'b1;
        if (idx >= dfd_pkg::HEADER_BYTES && idx == body)
            crc_lo = b;
        seen = idx + 1;
        rx_count = seen[16:0];

        if (idx >= dfd_pkg::HEADER_BYTES && seen == total)
        begin
            r.kind = dfd_pkg::KIND_VERDICT;
            if (start_bad)
                r.word.status = dfd_pkg::ST_START;
            else if ({b, crc_lo} != crc_acc)
                r.word.status = dfd_pkg::ST_CRC;
            else
            begin
                r.word.status = dfd_pkg::ST_OK;
                r.word.version = hdr_version;
                r.word.command = hdr_command;
                r.word.sequence_res = hdr_sequence;
                r.word.target_address = hdr_address;
                r.word.payload_length = hdr_length;
            end
            expected_results.push_back(r);
            if (last)
                restart_buffer();
            else
                frame_complete = 1'b1;
            return;
        end

        if (last)
        begin
            r.kind = dfd_pkg::KIND_VERDICT;
            // start error only wins once the minimum frame size was reached
            r.word.status = (seen >= dfd_pkg::HEADER_BYTES + 2 && start_bad) ?
                            dfd_pkg::ST_START : dfd_pkg::ST_LEN;
            expected_results.push_back(r);
            restart_buffer();
            return;
        end

        if (is_payload)
        begin
            r.word.payload_byte = b;
            expected_results.push_back(r);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.data;
                    s_tlast <= next_byte.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected transfer, expected none, actual kind %0b data 0x%0h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    observed_word = m_tdata;
                    check_field("item_kind", oldest_expected.kind, m_tuser);
                    check_field("payload_byte", oldest_expected.word.payload_byte,
                                observed_word.payload_byte);
                    check_field("status", oldest_expected.word.status, observed_word.status);
                    check_field("version", oldest_expected.word.version, observed_word.version);
                    check_field("command", oldest_expected.word.command, observed_word.command);
                    check_field("sequence_res", oldest_expected.word.sequence_res,
                                observed_word.sequence_res);
                    check_field("target_address", oldest_expected.word.target_address,
                                observed_word.target_address);
                    check_field("payload_length", oldest_expected.word.payload_length,
                                observed_word.payload_length);
                    check_field("spare bits", oldest_expected.word.spare, observed_word.spare);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Builds a complete frame with the current start bytes and a valid CRC.
    task automatic make_frame(input logic [15:0] len, input logic [7:0] ver,
                              input logic [7:0] cmd, input logic [15:0] seq,
                              input logic [31:0] addr, ref logic [7:0] frame[$]);
        logic [15:0] crc;
        frame.delete();
        frame.push_back(sof_first);
        frame.push_back(sof_second);
        frame.push_back(ver);
        frame.push_back(cmd);
        frame.push_back(seq[7:0]);
        frame.push_back(seq[15:8]);
        frame.push_back(addr[7:0]);
        frame.push_back(addr[15:8]);
        frame.push_back(addr[23:16]);
        frame.push_back(addr[31:24]);
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        repeat (len)
            frame.push_back(8'($urandom));
        crc = dfd_pkg::CRC_INIT;
        foreach (frame[i])
            crc = modbus_crc_step(crc, frame[i]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
    endtask

    task automatic queue_buffer(ref logic [7:0] frame[$]);
        stream_byte_t item;
        foreach (frame[i])
        begin
            item.data = frame[i];
            item.last = (i == frame.size() - 1);
            pending_bytes.push_back(item);
            bytes_queued++;
        end
    endtask

    task automatic trim_buffer(ref logic [7:0] frame[$], input int unsigned keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endtask

    // One random buffer: well-formed frames, damaged ones and noise.
    task automatic queue_random_buffer(output int unsigned counted);
        logic [7:0]  frame[$];
        logic [15:0] len;
        int unsigned shape;
        int unsigned pick;
        int unsigned pos;
        shape = $urandom_range(99);
        pick = $urandom_range(99);
        if (pick < 80)
            len = 16'($urandom_range(0, 6));
        else if (pick < 96)
            len = 16'($urandom_range(7, 40));
        else
            len = 16'($urandom_range(256, 300));
        if (shape < 8)
        begin
            repeat ($urandom_range(1, 20))
                frame.push_back(8'($urandom));
        end
        else
        begin
            make_frame(len, 8'($urandom), 8'($urandom), 16'($urandom), $urandom, frame);
            if (shape < 16)
            begin
                // header claims a long payload, buffer stops well short of it
                trim_buffer(frame, dfd_pkg::HEADER_BYTES);
                frame[dfd_pkg::OFS_LEN0] = 8'($urandom);
                frame[dfd_pkg::OFS_LEN1] = 8'($urandom_range(1, 255));
                repeat ($urandom_range(0, 20))
                    frame.push_back(8'($urandom));
            end
            else if (shape < 30)
            begin
                trim_buffer(frame, $urandom_range(1, frame.size() - 1));
            end
            else if (shape < 40)
            begin
                pos = $urandom_range(0, 1);
                frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (shape < 55)
            begin
                pos = $urandom_range(dfd_pkg::HEADER_BYTES, frame.size() - 1);
                frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        counted = frame.size();
        // junk after a completed frame is dropped by the block
        if (shape >= 30 && $urandom_range(99) < 35)
            repeat ($urandom_range(1, 4))
                frame.push_back(8'($urandom));
        queue_buffer(frame);
    endtask

    task automatic wait_for_drain();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic program_start_bytes(input logic [7:0] first, input logic [7:0] second);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= dfd_pkg::CFG_START_FIRST;
        cfg_data <= first;
        @(posedge clk);
        cfg_index <= dfd_pkg::CFG_START_SECOND;
        cfg_data <= second;
        @(posedge clk);
        cfg_we <= 1'b0;
        sof_first = first;
        sof_second = second;
        @(negedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned counted;
        int unsigned step;
        clear_deframer_model();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 81;
        program_start_bytes(8'h00, 8'hFF);

        // single-byte buffer: too short
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        queue_buffer(frame_bytes);
        // empty payload, good CRC, then junk up to the end flag
        make_frame(16'd0, 8'hFF, 8'h00, 16'hFFFF, 32'h0000_0000, frame_bytes);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        queue_buffer(frame_bytes);
        // buffer ends on the second payload byte of three
        make_frame(16'd3, 8'h00, 8'hFF, 16'h0000, 32'hFFFF_FFFF, frame_bytes);
        trim_buffer(frame_bytes, dfd_pkg::HEADER_BYTES + 2);
        queue_buffer(frame_bytes);
        wait_for_drain();

        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 38;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: program_start_bytes(8'hFF, 8'h00);
                1: program_start_bytes(8'hA5, 8'h5A);
                2: program_start_bytes(8'hFF, 8'hFF);
                4: program_start_bytes(8'h00, 8'h00);
                default: program_start_bytes(8'($urandom), 8'($urandom));
            endcase
            counted = 0;
            while (counted < BYTES_PER_SEGMENT)
            begin
                queue_random_buffer(step);
                counted += step;
            end
            wait_for_drain();
        end

        repeat (8)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dfd_pkg.sv
rtl/core/debug_frame_deframer_crc16.sv
tb/debug_frame_deframer_crc16_test.sv
